// File: rtl/core/msh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants of the mergeable sequence hash
// Command codes, the hash constants and the sequencer state type.
// ----------------------------------------------------------------------------
package msh_pkg;

  // command codes; codes 5 to 7 are no-ops
  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_APPEND   = 3'd1;
  localparam logic [2:0] CMD_COMBINE  = 3'd2;
  localparam logic [2:0] CMD_STRIP    = 3'd3;
  localparam logic [2:0] CMD_COMPARE  = 3'd4;

  // symbol finalizer multipliers, FNV prime and polynomial radix
  localparam logic [63:0] MIX_MUL1  = 64'h0000_0000_7feb_352d;
  localparam logic [63:0] MIX_MUL2  = 64'h0000_0000_846c_a68b;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] RADIX     = 64'h9e37_79b1_85eb_ca87;

  // sequencer states, one-hot
  typedef enum logic [14:0] {
    S_IDLE  = 15'b000_0000_0000_0001,
    S_MUL   = 15'b000_0000_0000_0010,
    S_AV2   = 15'b000_0000_0000_0100,
    S_AV3   = 15'b000_0000_0000_1000,
    S_APP1  = 15'b000_0000_0001_0000,
    S_APP2  = 15'b000_0000_0010_0000,
    S_APP3  = 15'b000_0000_0100_0000,
    S_POW   = 15'b000_0000_1000_0000,
    S_POWR  = 15'b000_0001_0000_0000,
    S_POWSQ = 15'b000_0010_0000_0000,
    S_CMB1  = 15'b000_0100_0000_0000,
    S_CMB2  = 15'b000_1000_0000_0000,
    S_STR1  = 15'b001_0000_0000_0000,
    S_STR2  = 15'b010_0000_0000_0000,
    S_DONE  = 15'b100_0000_0000_0000
  } state_t;

endpackage

// File: rtl/core/mergeable_sequence_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mergeable_sequence_hash_top: four-word mergeable polynomial hash accumulator
// Runs one command word at a time on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_* carries one command word (clear, append symbol,
//   append state, strip prefix, compare) with its operands. The block takes
//   a word only when its sequencer is idle; in_stall is high otherwise.
//   Output channel out_* returns the accumulator after every command, plus
//   the accepted and matches_res flags, from an output register.
//   All 64-bit products wrap mod 2^64 and are built from three 32x32
//   partial products on one multiplier. Clear, compare, no-op and refused
//   strip go straight to the result. Append symbol takes 5 multiplies;
//   append state and strip prefix take 2 multiplies plus the radix power
//   RADIX^e, where e is the operand length (append) or the remaining
//   length (strip).
//   The output register lets a new word be accepted while a result waits;
//   a finished result holds in the sequencer until the output slot frees.
//   Synchronous active-low reset zeroes the accumulator and empties the
//   output register.
// ----------------------------------------------------------------------------
module mergeable_sequence_hash_top
  import msh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_symbol,
  input  logic [63:0] in_operand_length,
  input  logic [63:0] in_operand_polynomial,
  input  logic [63:0] in_operand_sum,
  input  logic [63:0] in_operand_moment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_length,
  output logic [63:0] out_result_polynomial,
  output logic [63:0] out_result_sum,
  output logic [63:0] out_result_moment,
  output logic        out_accepted,
  output logic        out_matches_res
);

  // control
  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        strip_r, strip_nxt;
  logic        out_valid_r, out_valid_nxt;

  // accumulator
  logic [63:0] len_r, len_nxt;
  logic [63:0] poly_r, poly_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [63:0] mom_r, mom_nxt;

  // operands and work registers
  logic [63:0] ol_r, ol_nxt;
  logic [63:0] op_r, op_nxt;
  logic [63:0] os_r, os_nxt;
  logic [63:0] om_r, om_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] e_r, e_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] pw_r, pw_nxt;
  logic        ok_r, ok_nxt;
  logic        eq_r, eq_nxt;

  // multiplier
  logic [63:0] mul_a_r, mul_a_nxt;
  logic [63:0] mul_b_r, mul_b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mprod;

  // output register
  logic [63:0] o_len_r, o_len_nxt;
  logic [63:0] o_poly_r, o_poly_nxt;
  logic [63:0] o_sum_r, o_sum_nxt;
  logic [63:0] o_mom_r, o_mom_nxt;
  logic        o_ok_r, o_ok_nxt;
  logic        o_eq_r, o_eq_nxt;

  // finalizer intermediates
  logic [31:0] x1, m1, x2, m2, x3;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_length     = o_len_r;
  assign out_result_polynomial = o_poly_r;
  assign out_result_sum        = o_sum_r;
  assign out_result_moment     = o_mom_r;
  assign out_accepted          = o_ok_r;
  assign out_matches_res       = o_eq_r;

  // shared 32x32 multiplier: partial products lo*lo, lo*hi, hi*lo
  always_comb begin
    unique case (phase_r)
      2'd1: begin
        mop_a = mul_a_r[31:0];
        mop_b = mul_b_r[63:32];
      end
      2'd2: begin
        mop_a = mul_a_r[63:32];
        mop_b = mul_b_r[31:0];
      end
      default: begin
        mop_a = mul_a_r[31:0];
        mop_b = mul_b_r[31:0];
      end
    endcase
  end
  assign mprod = {32'd0, mop_a} * {32'd0, mop_b};

  // finalizer xor-shift steps
  assign x1 = in_symbol ^ (in_symbol >> 16);
  assign m1 = acc_r[31:0];
  assign x2 = m1 ^ (m1 >> 15);
  assign m2 = acc_r[31:0];
  assign x3 = m2 ^ (m2 >> 16);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    phase_nxt     = phase_r;
    strip_nxt     = strip_r;
    len_nxt       = len_r;
    poly_nxt      = poly_r;
    sum_nxt       = sum_r;
    mom_nxt       = mom_r;
    ol_nxt        = ol_r;
    op_nxt        = op_r;
    os_nxt        = os_r;
    om_nxt        = om_r;
    v_nxt         = v_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    pw_nxt        = pw_r;
    ok_nxt        = ok_r;
    eq_nxt        = eq_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_len_nxt     = o_len_r;
    o_poly_nxt    = o_poly_r;
    o_sum_nxt     = o_sum_r;
    o_mom_nxt     = o_mom_r;
    o_ok_nxt      = o_ok_r;
    o_eq_nxt      = o_eq_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ol_nxt   = in_operand_length;
          op_nxt   = in_operand_polynomial;
          os_nxt   = in_operand_sum;
          om_nxt   = in_operand_moment;
          ok_nxt   = 1'b1;
          eq_nxt   = 1'b0;
          base_nxt = RADIX;
          pw_nxt   = 64'd1;
          state_nxt = S_DONE;
          unique case (in_command)
            CMD_CLEAR: begin
              len_nxt  = '0;
              poly_nxt = '0;
              sum_nxt  = '0;
              mom_nxt  = '0;
            end
            CMD_APPEND: begin
              mul_a_nxt = {32'd0, x1};
              mul_b_nxt = MIX_MUL1;
              phase_nxt = 2'd0;
              ret_nxt   = S_AV2;
              state_nxt = S_MUL;
            end
            CMD_COMBINE: begin
              strip_nxt = 1'b0;
              e_nxt     = in_operand_length;
              state_nxt = S_POW;
            end
            CMD_STRIP: begin
              if (in_operand_length > len_r) begin
                ok_nxt = 1'b0;
              end else begin
                strip_nxt = 1'b1;
                e_nxt     = len_r - in_operand_length;
                state_nxt = S_POW;
              end
            end
            CMD_COMPARE: begin
              eq_nxt = (len_r == in_operand_length) &&
                       (poly_r == in_operand_polynomial) &&
                       (sum_r == in_operand_sum) &&
                       (mom_r == in_operand_moment);
            end
            default: ;
          endcase
        end
      end

      // 64x64 mod 2^64 multiply from three partial products
      S_MUL: begin
        phase_nxt = phase_r + 2'd1;
        prod_nxt  = mprod;
        unique case (phase_r)
          2'd0: ;
          2'd1: acc_nxt = prod_r;
          2'd2: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
          default: begin
            acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
            state_nxt = ret_r;
          end
        endcase
      end

      // symbol finalizer, then v = h * FNV prime
      S_AV2: begin
        mul_a_nxt = {32'd0, x2};
        mul_b_nxt = MIX_MUL2;
        phase_nxt = 2'd0;
        ret_nxt   = S_AV3;
        state_nxt = S_MUL;
      end
      S_AV3: begin
        mul_a_nxt = {32'd0, x3};
        mul_b_nxt = FNV_PRIME;
        phase_nxt = 2'd0;
        ret_nxt   = S_APP1;
        state_nxt = S_MUL;
      end
      S_APP1: begin
        v_nxt     = acc_r;
        mul_a_nxt = poly_r;
        mul_b_nxt = RADIX;
        phase_nxt = 2'd0;
        ret_nxt   = S_APP2;
        state_nxt = S_MUL;
      end
      S_APP2: begin
        poly_nxt  = acc_r + v_r;
        mul_a_nxt = len_r;
        mul_b_nxt = v_r;
        phase_nxt = 2'd0;
        ret_nxt   = S_APP3;
        state_nxt = S_MUL;
      end
      S_APP3: begin
        mom_nxt   = mom_r + acc_r;
        sum_nxt   = sum_r + v_r;
        len_nxt   = len_r + 64'd1;
        state_nxt = S_DONE;
      end

      // radix power by square and multiply
      S_POW: begin
        phase_nxt = 2'd0;
        state_nxt = S_MUL;
        if (e_r == 64'd0) begin
          mul_b_nxt = pw_r;
          if (strip_r) begin
            mul_a_nxt = op_r;
            ret_nxt   = S_STR1;
          end else begin
            mul_a_nxt = poly_r;
            ret_nxt   = S_CMB1;
          end
        end else if (e_r[0]) begin
          mul_a_nxt = pw_r;
          mul_b_nxt = base_r;
          ret_nxt   = S_POWR;
        end else begin
          mul_a_nxt = base_r;
          mul_b_nxt = base_r;
          ret_nxt   = S_POWSQ;
        end
      end
      S_POWR: begin
        pw_nxt = acc_r;
        if (e_r == 64'd1) begin
          // last set bit: no further squaring needed
          e_nxt     = '0;
          state_nxt = S_POW;
        end else begin
          mul_a_nxt = base_r;
          mul_b_nxt = base_r;
          phase_nxt = 2'd0;
          ret_nxt   = S_POWSQ;
          state_nxt = S_MUL;
        end
      end
      S_POWSQ: begin
        base_nxt  = acc_r;
        e_nxt     = e_r >> 1;
        state_nxt = S_POW;
      end

      // append state
      S_CMB1: begin
        poly_nxt  = acc_r + op_r;
        mul_a_nxt = len_r;
        mul_b_nxt = os_r;
        phase_nxt = 2'd0;
        ret_nxt   = S_CMB2;
        state_nxt = S_MUL;
      end
      S_CMB2: begin
        mom_nxt   = mom_r + om_r + acc_r;
        sum_nxt   = sum_r + os_r;
        len_nxt   = len_r + ol_r;
        state_nxt = S_DONE;
      end

      // strip prefix
      S_STR1: begin
        poly_nxt  = poly_r - acc_r;
        mul_a_nxt = ol_r;
        mul_b_nxt = sum_r - os_r;
        phase_nxt = 2'd0;
        ret_nxt   = S_STR2;
        state_nxt = S_MUL;
      end
      S_STR2: begin
        mom_nxt   = mom_r - om_r - acc_r;
        sum_nxt   = sum_r - os_r;
        len_nxt   = len_r - ol_r;
        state_nxt = S_DONE;
      end

      // hand the result word to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          o_len_nxt     = len_r;
          o_poly_nxt    = poly_r;
          o_sum_nxt     = sum_r;
          o_mom_nxt     = mom_r;
          o_ok_nxt      = ok_r;
          o_eq_nxt      = eq_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= 2'd0;
      strip_r     <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      poly_r      <= '0;
      sum_r       <= '0;
      mom_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      phase_r     <= phase_nxt;
      strip_r     <= strip_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      poly_r      <= poly_nxt;
      sum_r       <= sum_nxt;
      mom_r       <= mom_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ol_r     <= ol_nxt;
    op_r     <= op_nxt;
    os_r     <= os_nxt;
    om_r     <= om_nxt;
    v_r      <= v_nxt;
    e_r      <= e_nxt;
    base_r   <= base_nxt;
    pw_r     <= pw_nxt;
    ok_r     <= ok_nxt;
    eq_r     <= eq_nxt;
    mul_a_r  <= mul_a_nxt;
    mul_b_r  <= mul_b_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    o_len_r  <= o_len_nxt;
    o_poly_r <= o_poly_nxt;
    o_sum_r  <= o_sum_nxt;
    o_mom_r  <= o_mom_nxt;
    o_ok_r   <= o_ok_nxt;
    o_eq_r   <= o_eq_nxt;
  end

endmodule
